@@ src/rbr_pkg.sv @@
// Shared types and constants for the 4-bit packed-pixel raster-op blitter row core.
`timescale 1ns / 1ps

package rbr_pkg;

    // Fixed field widths
    localparam int unsigned PIX_BYTE_W  = 8;
    localparam int unsigned WIDTH_REG_W = 13;
    localparam int unsigned CFG_IDX_W   = 8;

    // Edge masks
    localparam logic [7:0] MASK_LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] MASK_HIGH_NIBBLE = 8'hF0;
    localparam logic [7:0] MASK_FULL        = 8'hFF;

    // Edge table: indexed by pixel offset into the byte (0, 1, 2 or more)
    localparam logic [7:0] EDGE_TABLE [3] = '{8'hFF, 8'h0F, 8'h00};

    // Raster operations
    typedef enum logic [1:0] {
        ROP_COPY = 2'd0,
        ROP_OR   = 2'd1,
        ROP_AND  = 2'd2,
        ROP_XOR  = 2'd3
    } rop_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_OP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 8'd3;

    // Configuration bundle
    typedef struct packed {
        rop_t                   raster_op;
        logic                   src_nibble_offset;
        logic                   dst_nibble_offset;
        logic [WIDTH_REG_W-1:0] width_pixels;
    } cfg_t;

    // Input beat
    typedef struct packed {
        logic [PIX_BYTE_W-1:0] src_first_byte;
        logic [PIX_BYTE_W-1:0] src_second_byte;
        logic [PIX_BYTE_W-1:0] old_dest_byte;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [PIX_BYTE_W-1:0] new_dest_byte;
        logic [PIX_BYTE_W-1:0] byte_mask;
        logic                  row_end;
    } out_beat_t;

    // Edge information for one destination byte
    typedef struct packed {
        logic [PIX_BYTE_W-1:0] mask;
        logic                  last;
    } edge_info_t;

endpackage

@@ src/packed4_rop_blit_row.sv @@
// Top level of the 4-bit packed-pixel raster-op blitter row core.
`timescale 1ns / 1ps

// Takes one destination byte of a blit row per beat: two consecutive source
// bytes and the old destination byte. Returns the new destination byte, the
// edge mask applied and a row-end flag. One beat is accepted every cycle
// unless the output register is full and stalled; an accepted beat sits in
// the input stage register and its result moves into the output register
// once that register is free or draining. The row position advances when
// a beat is accepted, so beats must be fed in row order. Configuration
// writes are always accepted and any write to a listed register starts a
// new row; write only while no beat is in flight. Widths above MAX_WIDTH
// are clamped.
module packed4_rop_blit_row
#(
    parameter int unsigned MAX_WIDTH = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rbr_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rbr_pkg::out_beat_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbr_pkg::WIDTH_REG_W-1:0] cfg_data
);
    import rbr_pkg::*;

    cfg_t       cfg;
    logic       cfg_write;
    logic       in_take;
    logic       stage_move;
    edge_info_t edge_info;
    out_beat_t  result;

    logic       stage_valid_reg;
    in_beat_t   stage_beat_reg;
    edge_info_t stage_edge_reg;
    logic       out_valid_reg;
    out_beat_t  out_beat_reg;

    rbr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_write (cfg_write)
    );

    rbr_edge_gen #(.MAX_WIDTH(MAX_WIDTH)) u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_write (cfg_write),
        .advance   (in_take),
        .edge_info (edge_info)
    );

    rbr_rop u_rop
    (
        .cfg       (cfg),
        .beat      (stage_beat_reg),
        .edge_info (stage_edge_reg),
        .result    (result)
    );

    // Handshake: the stage moves when the output register is free or draining
    assign stage_move = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_move;
    assign in_take    = in_valid && in_ready;

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_beat_reg <= in_data;
            stage_edge_reg <= edge_info;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_move)
            out_beat_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

endmodule

@@ src/rbr_cfg_regs.sv @@
// Configuration register file of the blitter row core.
`timescale 1ns / 1ps

module rbr_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbr_pkg::WIDTH_REG_W-1:0] cfg_data,
    output rbr_pkg::cfg_t                 cfg,
    output logic                          cfg_write
);
    import rbr_pkg::*;

    cfg_t cfg_reg;

    // Always take configuration beats
    assign cfg_ready = 1'b1;

    // A write to any listed register restarts the row
    always_comb
    begin
        unique case (cfg_index)
            CFG_RASTER_OP, CFG_SRC_OFFSET, CFG_DST_OFFSET, CFG_WIDTH:
                cfg_write = cfg_valid;
            default:
                cfg_write = 1'b0;
        endcase
    end

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raster_op         <= ROP_COPY;
            cfg_reg.src_nibble_offset <= 1'b0;
            cfg_reg.dst_nibble_offset <= 1'b0;
            cfg_reg.width_pixels      <= WIDTH_REG_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RASTER_OP:  cfg_reg.raster_op         <= rop_t'(cfg_data[1:0]);
                CFG_SRC_OFFSET: cfg_reg.src_nibble_offset <= cfg_data[0];
                CFG_DST_OFFSET: cfg_reg.dst_nibble_offset <= cfg_data[0];
                CFG_WIDTH:      cfg_reg.width_pixels      <= cfg_data;
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/rbr_edge_gen.sv @@
// Row byte counter and edge mask generation.
`timescale 1ns / 1ps

module rbr_edge_gen
#(
    parameter int unsigned MAX_WIDTH = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rbr_pkg::cfg_t          cfg,
    input  logic                   cfg_write,
    input  logic                   advance,
    output rbr_pkg::edge_info_t    edge_info
);
    import rbr_pkg::*;

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH / 2 + 1);
    localparam int unsigned SPAN_W = WIDTH_REG_W + 1;
    localparam int unsigned CMP_W  = (COL_W + 1 > SPAN_W) ? COL_W + 1 : SPAN_W;
    localparam logic [31:0] MAX_WIDTH_W = 32'(MAX_WIDTH);

    logic [COL_W-1:0]       column_reg;
    logic [COL_W-1:0]       column_next;
    logic [WIDTH_REG_W-1:0] eff_width;
    logic [SPAN_W-1:0]      span;
    logic [SPAN_W-1:0]      nbytes;
    logic                   single_byte;
    logic                   last;
    logic [1:0]             hi_idx;
    logic [7:0]             mask;

    // Clamp the width and size the row in bytes
    always_comb
    begin
        if (32'(cfg.width_pixels) > MAX_WIDTH_W)
            eff_width = WIDTH_REG_W'(MAX_WIDTH);
        else
            eff_width = cfg.width_pixels;
        span        = SPAN_W'(eff_width) + SPAN_W'(cfg.dst_nibble_offset);
        nbytes      = SPAN_W'(((SPAN_W + 1)'(span) + (SPAN_W + 1)'(1)) >> 1);
        single_byte = (nbytes <= SPAN_W'(1));
        last        = (CMP_W'(column_reg) + CMP_W'(1)) >= CMP_W'(nbytes);
        hi_idx      = (span > SPAN_W'(2)) ? 2'd2 : span[1:0];
    end

    // Pick the edge mask for the current byte
    always_comb
    begin
        priority if (single_byte)
            mask = EDGE_TABLE[{1'b0, cfg.dst_nibble_offset}] & ~EDGE_TABLE[hi_idx];
        else if ((column_reg == '0) && cfg.dst_nibble_offset)
            mask = MASK_LOW_NIBBLE;
        else if (last && span[0])
            mask = MASK_HIGH_NIBBLE;
        else
            mask = MASK_FULL;
    end

    // Advance the column, wrapping at the row end; a configuration write restarts it at zero
    always_comb
    begin
        priority if (cfg_write)
            column_next = '0;
        else if (advance)
            column_next = last ? '0 : column_reg + COL_W'(1);
        else
            column_next = column_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            column_reg <= '0;
        else
            column_reg <= column_next;
    end

    assign edge_info.mask = mask;
    assign edge_info.last = last;

endmodule

@@ src/rbr_rop.sv @@
// Source alignment and masked raster operation on one destination byte.
`timescale 1ns / 1ps

module rbr_rop
(
    input  rbr_pkg::cfg_t       cfg,
    input  rbr_pkg::in_beat_t   beat,
    input  rbr_pkg::edge_info_t edge_info,
    output rbr_pkg::out_beat_t  result
);
    import rbr_pkg::*;

    logic [7:0] data;
    logic [7:0] mask;
    logic [7:0] old;
    logic [7:0] value;

    // Shift the source by a nibble when the offsets differ
    always_comb
    begin
        mask = edge_info.mask;
        old  = beat.old_dest_byte;
        if (cfg.src_nibble_offset != cfg.dst_nibble_offset)
            data = {beat.src_first_byte[3:0], beat.src_second_byte[7:4]};
        else
            data = beat.src_first_byte;
    end

    // Combine with the old destination under the mask
    always_comb
    begin
        unique case (cfg.raster_op)
            ROP_COPY: value = (data & mask) | (old & ~mask);
            ROP_OR:   value = old | (data & mask);
            ROP_AND:  value = old & (data | ~mask);
            ROP_XOR:  value = old ^ (data & mask);
            default:  value = old;
        endcase
    end

    assign result.new_dest_byte = value;
    assign result.byte_mask     = mask;
    assign result.row_end       = edge_info.last;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the 4-bit packed-pixel raster-op blitter row core.
`timescale 1ns / 1ps

module tb;
    import rbr_pkg::*;

    localparam int MAX_WIDTH   = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_TAIL  = 150;   // beats at the end with no idling
    localparam int HOLD_AT     = 20;    // result count that starts the long hold-off
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {ACT_BEAT, ACT_CFG} act_kind_t;

    typedef struct {
        act_kind_t                kind;
        in_beat_t                 beat;
        logic [CFG_IDX_W-1:0]     idx;
        logic [WIDTH_REG_W-1:0]   val;
    } blit_act_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_beat_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_beat_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WIDTH_REG_W-1:0] cfg_data = '0;

    // Stimulus and expected destination bytes
    blit_act_t  pending_q[$];
    out_beat_t  dest_byte_q[$];
    int         total_beats = 0;
    int         beats_taken = 0;
    int         errors = 0;
    int         cycle_count = 0;

    // Shadow of the register file and row position, for the prediction
    rop_t                   mdl_rop = ROP_COPY;
    logic                   mdl_src = 1'b0;
    logic                   mdl_dst = 1'b0;
    logic [WIDTH_REG_W-1:0] mdl_width = WIDTH_REG_W'(1);
    int                     mdl_column = 0;

    // Shadow used while building the stimulus, to know where rows end
    logic                   sh_dst = 1'b0;
    int                     sh_width = 1;
    int                     sh_col = 0;

    packed4_rop_blit_row #(.MAX_WIDTH(MAX_WIDTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Number of destination bytes a row covers
    function automatic int row_len(logic dst, int width);
        int w;
        int n;
        w = (width > MAX_WIDTH) ? MAX_WIDTH : width;
        n = (int'(dst) + w + 1) / 2;
        return (n == 0) ? 1 : n;
    endfunction

    // Work out the written destination byte for one beat and advance the row
    function automatic out_beat_t blit_byte(in_beat_t b);
        int         span;
        int         nbytes;
        logic [7:0] data;
        logic [7:0] mask;
        logic [7:0] res;
        logic       last;
        out_beat_t  r;
        span   = int'(mdl_dst) + ((mdl_width > MAX_WIDTH) ? MAX_WIDTH : int'(mdl_width));
        nbytes = row_len(mdl_dst, mdl_width);
        last   = (mdl_column + 1 >= nbytes);
        if (mdl_src != mdl_dst)
            data = {b.src_first_byte[3:0], b.src_second_byte[7:4]};
        else
            data = b.src_first_byte;
        if (nbytes == 1)
            mask = EDGE_TABLE[mdl_dst] & ~EDGE_TABLE[(span > 2) ? 2 : span];
        else if (mdl_column == 0 && mdl_dst)
            mask = MASK_LOW_NIBBLE;
        else if (last && span[0])
            mask = MASK_HIGH_NIBBLE;
        else
            mask = MASK_FULL;
        case (mdl_rop)
            ROP_COPY: res = (data & mask) | (b.old_dest_byte & ~mask);
            ROP_OR:   res = b.old_dest_byte | (data & mask);
            ROP_AND:  res = b.old_dest_byte & (data | ~mask);
            default:  res = b.old_dest_byte ^ (data & mask);
        endcase
        r.new_dest_byte = res;
        r.byte_mask     = mask;
        r.row_end       = last;
        mdl_column = last ? 0 : mdl_column + 1;
        return r;
    endfunction

    // Update the register shadow; an unlisted index leaves everything alone
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_REG_W-1:0] val);
        case (idx)
            CFG_RASTER_OP:  mdl_rop = rop_t'(val[1:0]);
            CFG_SRC_OFFSET: mdl_src = val[0];
            CFG_DST_OFFSET: mdl_dst = val[0];
            CFG_WIDTH:      mdl_width = val;
            default:        return;
        endcase
        mdl_column = 0;
    endfunction

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int val);
        blit_act_t a;
        a.kind = ACT_CFG;
        a.beat = '0;
        a.idx  = idx;
        a.val  = val[WIDTH_REG_W-1:0];
        pending_q.push_back(a);
        case (idx)
            CFG_RASTER_OP, CFG_SRC_OFFSET: sh_col = 0;
            CFG_DST_OFFSET: begin sh_dst = a.val[0]; sh_col = 0; end
            CFG_WIDTH:      begin sh_width = int'(a.val); sh_col = 0; end
            default: ;
        endcase
    endtask

    task automatic put_beat(logic [7:0] first, logic [7:0] second, logic [7:0] old);
        blit_act_t a;
        a.kind = ACT_BEAT;
        a.beat.src_first_byte  = first;
        a.beat.src_second_byte = second;
        a.beat.old_dest_byte   = old;
        a.idx = '0;
        a.val = '0;
        pending_q.push_back(a);
        total_beats++;
        sh_col = (sh_col + 1 >= row_len(sh_dst, sh_width)) ? 0 : sh_col + 1;
    endtask

    task automatic put_beats(int n);
        bit [23:0] r;
        repeat (n)
        begin
            r = 24'($urandom);
            put_beat(r[23:16], r[15:8], r[7:0]);
        end
    endtask

    // Build the stimulus, release reset, then wait for the last result
    initial
    begin : stim_p
        int  pick;
        int  len;
        bit  wrote;
        // Reset state: copy, width one, both offsets zero
        put_beat(8'hFF, 8'h00, 8'h00);
        put_beat(8'h00, 8'hFF, 8'hFF);
        // Destination offset one, single pixel in the low nibble, shifted source
        put_reg(CFG_DST_OFFSET, 1);
        put_beat(8'hA5, 8'h3C, 8'hC3);
        // Zero width: empty mask, byte passes through
        put_reg(CFG_WIDTH, 0);
        put_beat(8'hFF, 8'hFF, 8'h5A);
        put_reg(CFG_DST_OFFSET, 0);
        put_beat(8'hFF, 8'hFF, 8'hA5);
        // Every raster op on a full byte with a shifted source
        put_reg(CFG_WIDTH, 2);
        put_reg(CFG_SRC_OFFSET, 1);
        put_reg(CFG_RASTER_OP, ROP_OR);
        put_beat(8'h5A, 8'hC3, 8'h0F);
        put_reg(CFG_RASTER_OP, ROP_AND);
        put_beat(8'h5A, 8'hC3, 8'hF0);
        put_reg(CFG_RASTER_OP, ROP_XOR);
        put_beat(8'hFF, 8'h00, 8'h3C);
        put_reg(CFG_RASTER_OP, ROP_COPY);
        put_beat(8'h00, 8'hFF, 8'hFF);
        // Leading edge then full byte; leading edge then trailing edge
        put_reg(CFG_DST_OFFSET, 1);
        put_reg(CFG_WIDTH, 3);
        put_beats(2);
        put_reg(CFG_WIDTH, 2);
        put_beats(2);
        // Three-byte row broken by writes to unlisted indexes, which keep the position
        put_reg(CFG_DST_OFFSET, 0);
        put_reg(CFG_WIDTH, 5);
        put_beats(1);
        put_reg(CFG_IDX_W'(CFG_WIDTH + 1), 8191);
        put_beats(1);
        put_reg(8'hFF, 0);
        put_beats(1);
        // Long run of the widest row, clamped to the maximum width; the long
        // receiver hold-off lands here so the pipeline fills
        put_reg(CFG_WIDTH, 8191);
        put_reg(CFG_DST_OFFSET, 1);
        put_beats(60);

        // Random phases: new settings, whole rows with random content, some broken rows
        while (total_beats < 600)
        begin
            wrote = 0;
            if ($urandom_range(0, 1))
            begin
                put_reg(CFG_RASTER_OP, $urandom_range(0, 8191));
                wrote = 1;
            end
            if ($urandom_range(0, 1))
            begin
                put_reg(CFG_SRC_OFFSET, $urandom_range(0, 8191));
                wrote = 1;
            end
            if ($urandom_range(0, 1))
            begin
                put_reg(CFG_DST_OFFSET, $urandom_range(0, 8191));
                wrote = 1;
            end
            if ($urandom_range(0, 3) != 0 || !wrote)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    put_reg(CFG_WIDTH, 0);
                else if (pick == 1)
                    put_reg(CFG_WIDTH, $urandom_range(MAX_WIDTH, 8191));
                else if (pick == 2)
                    put_reg(CFG_WIDTH, MAX_WIDTH);
                else
                    put_reg(CFG_WIDTH, $urandom_range(1, 40));
            end
            if ($urandom_range(0, 7) == 0)
                put_reg(CFG_IDX_W'($urandom_range(CFG_WIDTH + 1, 255)),
                        $urandom_range(0, 8191));
            len = row_len(sh_dst, sh_width);
            if (len > 64)
                put_beats($urandom_range(5, 30));
            else
            begin
                repeat ($urandom_range(1, 4))
                    put_beats(len);
                if ($urandom_range(0, 3) == 0)
                begin
                    put_beats($urandom_range(1, len));
                    if ($urandom_range(0, 1))
                    begin
                        put_reg(CFG_IDX_W'($urandom_range(CFG_WIDTH + 1, 255)),
                                $urandom_range(0, 8191));
                        put_beats(len - sh_col);
                    end
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain, then let the pipeline settle
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || cfg_valid || dest_byte_q.size() != 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: present pixel beats and register writes, with random gaps
    always @(posedge clk or negedge rst_n)
    begin : feed_p
        logic                   nxt_valid;
        in_beat_t               nxt_data;
        logic                   nxt_cfg_valid;
        logic [CFG_IDX_W-1:0]   nxt_idx;
        logic [WIDTH_REG_W-1:0] nxt_val;
        blit_act_t              a;
        int                     gap_left;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            gap_left  = 0;
        end
        else
        begin
            nxt_valid     = in_valid;
            nxt_data      = in_data;
            nxt_cfg_valid = cfg_valid;
            nxt_idx       = cfg_index;
            nxt_val       = cfg_data;
            if (in_valid && in_ready)
            begin
                dest_byte_q.push_back(blit_byte(in_data));
                beats_taken++;
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    if (pending_q[0].kind == ACT_BEAT)
                    begin
                        if (beats_taken < total_beats - QUIET_TAIL && $urandom_range(0, 5) == 0)
                            gap_left = $urandom_range(1, 16);
                        else
                        begin
                            a = pending_q.pop_front();
                            nxt_valid = 1'b1;
                            nxt_data  = a.beat;
                        end
                    end
                    // Hold register writes until every result is back
                    else if (dest_byte_q.size() == 0)
                    begin
                        a = pending_q.pop_front();
                        nxt_cfg_valid = 1'b1;
                        nxt_idx       = a.idx;
                        nxt_val       = a.val;
                    end
                end
            end
            in_valid  <= nxt_valid;
            in_data   <= nxt_data;
            cfg_valid <= nxt_cfg_valid;
            cfg_index <= nxt_idx;
            cfg_data  <= nxt_val;
        end
    end

    // Receiver back-pressure: random stall bursts and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : sink_p
        int stall_left;
        int rx_count;
        bit hold_done;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            rx_count   = 0;
            hold_done  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                rx_count++;
            if (!hold_done && rx_count >= HOLD_AT)
            begin
                hold_done  = 1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_count < total_beats - QUIET_TAIL
                     && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: compare each result beat with the oldest expected byte
    always @(posedge clk)
    begin : check_p
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (dest_byte_q.size() == 0)
            begin
                $error("unexpected result beat: new_dest_byte %h byte_mask %h row_end %b",
                       out_data.new_dest_byte, out_data.byte_mask, out_data.row_end);
                errors++;
            end
            else
            begin
                want = dest_byte_q.pop_front();
                if (out_data.new_dest_byte !== want.new_dest_byte)
                begin
                    $error("new_dest_byte: expected %h, actual %h",
                           want.new_dest_byte, out_data.new_dest_byte);
                    errors++;
                end
                if (out_data.byte_mask !== want.byte_mask)
                begin
                    $error("byte_mask: expected %h, actual %h",
                           want.byte_mask, out_data.byte_mask);
                    errors++;
                end
                if (out_data.row_end !== want.row_end)
                begin
                    $error("row_end: expected %b, actual %b", want.row_end, out_data.row_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
